[hdl/sba_pkg.sv]
// sba_pkg: constants, size-class tables, controller states and the command and
// status structs of the segregated block allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

    localparam int NUM_CLASSES  = 8;
    localparam int SEG_BYTES    = 4096;
    localparam int MIN_BLOCK    = 16;
    localparam int LINK_BYTES   = 4;
    localparam int HEADER_BYTES = 12;

    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 16;
    localparam int SEG_LOG = $clog2(SEG_BYTES);
    localparam int MIN_LOG = $clog2(MIN_BLOCK);
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int SLOT_W  = SEG_LOG - MIN_LOG;

    localparam int IN_TDATA_W  = ((BYTES_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_W + 7) / 8) * 8;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // blocks in a class: segment / block size, minus one for the header
    function automatic int cls_count(input int c);
        int sh;
        int q;
        sh = SEG_LOG - MIN_LOG - c;
        q  = (sh < 0) ? 0 : (1 << sh);
        return (q > 1) ? q - 1 : 0;
    endfunction

    // first link-store entry of a class
    function automatic int cls_first(input int c);
        int acc;
        acc = 0;
        for (int k = 0; k < c; k++) begin
            acc += cls_count(k);
        end
        return acc;
    endfunction

    localparam int TOTAL_SLOTS = cls_first(NUM_CLASSES);
    localparam int LIDX_W      = $clog2(TOTAL_SLOTS);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_UPD
    } t_state;

    typedef struct packed {
        logic init_step;
        logic load_req;
        logic alloc_rd;
        logic alloc_upd;
        logic free_upd;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic req_free;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[hdl/sba_ctrl.sv]
// sba_ctrl: sequencer of the allocator, one request at a time
// depends on sba_pkg
`timescale 1ns / 1ps
`default_nettype none

module sba_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire sba_pkg::t_status i_status,
    output sba_pkg::t_cmd        o_cmd
);
    import sba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_status.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.req_free) begin
                    // free finishes here once the result register can take it
                    if (i_status.out_free) begin
                        o_cmd.free_upd = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.alloc_rd = 1'b1;
                    n_state        = S_UPD;
                end
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.alloc_upd = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/sba_datapath.sv]
// sba_datapath: heap base, per-class list registers, link memory, address math
// and the result register
// depends on sba_pkg
`timescale 1ns / 1ps
`default_nettype none

module sba_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [sba_pkg::ADDR_W-1:0]          i_cfg_data,
    input  wire logic [sba_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  wire logic                                i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [sba_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    output logic                                     o_m_tuser,
    input  wire sba_pkg::t_cmd                       i_cmd,
    output sba_pkg::t_status                         o_status
);
    import sba_pkg::*;

    // size-class tables, folded to constants
    logic [SLOT_W-1:0] w_count [NUM_CLASSES];
    logic [LIDX_W-1:0] w_first [NUM_CLASSES];

    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            w_count[i] = SLOT_W'(cls_count(i));
            w_first[i] = LIDX_W'(cls_first(i));
        end
    end

    logic [ADDR_W-1:0]  r_base;
    logic               r_type;
    logic [BYTES_W-1:0] r_bytes;
    logic [ADDR_W-1:0]  r_addr;

    logic [SLOT_W-1:0]  r_head  [NUM_CLASSES];
    logic [SLOT_W-1:0]  r_tail  [NUM_CLASSES];
    logic               r_empty [NUM_CLASSES];

    logic [SLOT_W-1:0]  r_link [TOTAL_SLOTS];
    logic [SLOT_W-1:0]  r_rd_data;

    logic [CLS_W-1:0]   r_cls;
    logic               r_hit;
    logic [ADDR_W-1:0]  r_pa;

    logic [CLS_W-1:0]   r_ini_cls;
    logic [SLOT_W-1:0]  r_ini_slot;
    logic [LIDX_W-1:0]  r_ini_g;

    logic               r_out_valid;
    logic               r_out_granted;
    logic [ADDR_W-1:0]  r_out_addr;

    // configuration is always taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type  <= i_s_tuser;
            r_bytes <= i_s_tdata[BYTES_W-1:0];
            r_addr  <= i_s_tdata[BYTES_W +: ADDR_W];
        end
    end

    // allocate: first class that fits and has a free block
    logic [BYTES_W:0]   w_need;
    logic               w_hit;
    logic [CLS_W-1:0]   w_cls;
    logic [SLOT_W-1:0]  w_head_sel;
    logic [ADDR_W-1:0]  w_pa;
    logic [LIDX_W-1:0]  w_rd_idx;

    assign w_need = {1'b0, r_bytes} + (BYTES_W + 1)'(LINK_BYTES);

    always_comb begin
        w_hit = 1'b0;
        w_cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (((32'(MIN_BLOCK) << c) >= 32'(w_need)) && !r_empty[c]) begin
                w_hit = 1'b1;
                w_cls = CLS_W'(c);
            end
        end
    end

    assign w_head_sel = r_head[w_cls];
    assign w_pa       = r_base + (ADDR_W'(w_cls) << SEG_LOG)
                        + ADDR_W'(HEADER_BYTES + LINK_BYTES)
                        + (ADDR_W'(w_head_sel) << (MIN_LOG + int'(w_cls)));
    assign w_rd_idx   = w_first[w_cls] + LIDX_W'(w_head_sel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_rd) begin
            r_cls     <= w_cls;
            r_hit     <= w_hit;
            r_pa      <= w_pa;
            r_rd_data <= r_link[w_rd_idx];
        end
    end

    // free: class and slot straight from the address
    logic [ADDR_W-1:0]  w_off;
    logic [CLS_W-1:0]   w_fcls;
    logic [SEG_LOG-1:0] w_rel;
    logic [SEG_LOG-1:0] w_slot_full;
    logic [SLOT_W-1:0]  w_slot;
    logic               w_free_ok;
    logic [LIDX_W-1:0]  w_wr_tail_idx;

    assign w_off       = r_addr - ADDR_W'(LINK_BYTES) - r_base;
    assign w_fcls      = w_off[SEG_LOG +: CLS_W];
    assign w_rel       = w_off[SEG_LOG-1:0];
    assign w_slot_full = (w_rel - SEG_LOG'(HEADER_BYTES)) >> (MIN_LOG + int'(w_fcls));
    assign w_slot      = w_slot_full[SLOT_W-1:0];
    assign w_free_ok   = (r_addr != '0)
                         && (w_off[ADDR_W-1:SEG_LOG] < (ADDR_W - SEG_LOG)'(NUM_CLASSES))
                         && (w_rel >= SEG_LOG'(HEADER_BYTES))
                         && (w_slot_full < SEG_LOG'(w_count[w_fcls]));
    assign w_wr_tail_idx = w_first[w_fcls] + LIDX_W'(r_tail[w_fcls]);

    // link memory write port: reset sweep or tail append
    logic               w_wr_en;
    logic [LIDX_W-1:0]  w_wr_idx;
    logic [SLOT_W-1:0]  w_wr_data;
    logic               w_ini_cls_end;

    assign w_ini_cls_end = (r_ini_slot + SLOT_W'(1)) >= w_count[r_ini_cls];

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_idx  = w_wr_tail_idx;
        w_wr_data = w_slot;
        if (i_cmd.init_step) begin
            w_wr_en   = 1'b1;
            w_wr_idx  = r_ini_g;
            w_wr_data = w_ini_cls_end ? '0 : r_ini_slot + SLOT_W'(1);
        end else if (i_cmd.free_upd && w_free_ok && !r_empty[w_fcls]) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_link[w_wr_idx] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ini_cls  <= '0;
            r_ini_slot <= '0;
            r_ini_g    <= '0;
        end else if (i_cmd.init_step) begin
            r_ini_g <= r_ini_g + LIDX_W'(1);
            if (w_ini_cls_end) begin
                r_ini_cls  <= r_ini_cls + CLS_W'(1);
                r_ini_slot <= '0;
            end else begin
                r_ini_slot <= r_ini_slot + SLOT_W'(1);
            end
        end
    end

    // list registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_tail[c]  <= (w_count[c] != '0) ? w_count[c] - SLOT_W'(1) : '0;
                r_empty[c] <= (w_count[c] == '0);
            end
        end else if (i_cmd.alloc_upd && r_hit) begin
            if (r_head[r_cls] == r_tail[r_cls]) begin
                r_empty[r_cls] <= 1'b1;
            end else if (r_rd_data < w_count[r_cls]) begin
                r_head[r_cls] <= r_rd_data;
            end else begin
                r_empty[r_cls] <= 1'b1;
            end
        end else if (i_cmd.free_upd && w_free_ok) begin
            if (r_empty[w_fcls]) begin
                r_head[w_fcls]  <= w_slot;
                r_empty[w_fcls] <= 1'b0;
            end
            r_tail[w_fcls] <= w_slot;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.alloc_upd || i_cmd.free_upd) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_upd) begin
            r_out_granted <= r_hit;
            r_out_addr    <= r_hit ? r_pa : '0;
        end else if (i_cmd.free_upd) begin
            r_out_granted <= 1'b0;
            r_out_addr    <= '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_granted;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_addr);

    assign o_status.init_last = (r_ini_g == LIDX_W'(TOTAL_SLOTS - 1));
    assign o_status.req_free  = (r_type == REQ_FREE);
    assign o_status.out_free  = !r_out_valid || i_m_tready;

endmodule

`default_nettype wire

[hdl/segregated_block_allocator_top.sv]
// Segregated free-list block allocator. Eight size classes of 16 to 2048 byte
// blocks, one 4096 byte segment each behind a 12 byte header, starting at the
// configured heap base. Each request (tuser 0 allocate, 1 free) gives exactly
// one result: tuser is the grant flag and tdata the payload address (link word
// skipped) or zero. After reset the link memory is walked once to chain every
// class, while no request is taken; configuration writes are taken at any
// time but belong only to idle periods. A free is accepted and then finishes
// in the evaluate state; an allocate is accepted, evaluated and then updated,
// since it waits on one registered read of the next-link memory. A waiting
// result holds the next request's final state until it is taken.
// depends on sba_pkg, sba_ctrl, sba_datapath
`timescale 1ns / 1ps
`default_nettype none

module segregated_block_allocator_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration: heap_base
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sba_pkg::ADDR_W-1:0]        i_cfg_data,
    // requests
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [sba_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // req_bytes, free_addr
    input  wire logic                              s_axis_tuser,  // req_type
    // results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [sba_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // block_addr
    output logic                                   m_axis_tuser   // granted
);
    import sba_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    sba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sba_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

`default_nettype wire

[tb/sba_checker.sv]
// sba_checker: watches the config, request and result channels of the allocator,
// keeps its own copy of the free lists and compares every result item in order
// depends on sba_pkg
`timescale 1ns / 1ps

module sba_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [sba_pkg::ADDR_W-1:0]      i_cfg_data,
    input  wire logic                            i_req_valid,
    input  wire logic                            i_req_ready,
    input  wire logic [sba_pkg::IN_TDATA_W-1:0]  i_req_data,   // req_bytes, free_addr
    input  wire logic                            i_req_user,   // req_type
    input  wire logic                            i_res_valid,
    input  wire logic                            i_res_ready,
    input  wire logic [sba_pkg::OUT_TDATA_W-1:0] i_res_data,   // block_addr
    input  wire logic                            i_res_user,   // granted
    output int                                   o_errors,
    output int                                   o_outstanding
);
    import sba_pkg::*;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] addr;
    } t_grant;

    localparam int LINK_DEPTH = 2 * SEG_BYTES / MIN_BLOCK + 1;

    t_grant            pending_grants[$];
    logic [ADDR_W-1:0] heap_base;
    int                list_head  [NUM_CLASSES];
    int                list_tail  [NUM_CLASSES];
    logic              list_empty [NUM_CLASSES];
    int                class_slots[NUM_CLASSES];
    int                class_start[NUM_CLASSES];
    int                slot_link  [LINK_DEPTH];
    int                result_no;

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("[%0t] result %0d: %s got %h expected %h", $realtime, result_no, what,
                 got, want);
        o_errors++;
    endtask

    // every class starts with all of its slots chained in order
    task automatic reset_lists();
        int acc;
        int q;
        acc = 0;
        heap_base = '0;
        for (int g = 0; g < LINK_DEPTH; g++) slot_link[g] = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            q = SEG_BYTES / (MIN_BLOCK << c);
            class_slots[c] = (q > 1) ? q - 1 : 0;
            class_start[c] = acc;
            for (int s = 0; s + 1 < class_slots[c]; s++) slot_link[acc + s] = s + 1;
            acc += class_slots[c];
            list_head[c]  = 0;
            list_tail[c]  = (class_slots[c] > 0) ? class_slots[c] - 1 : 0;
            list_empty[c] = (class_slots[c] == 0);
        end
    endtask

    task automatic serve_request(input logic kind, input logic [BYTES_W-1:0] nbytes,
                                 input logic [ADDR_W-1:0] addr);
        t_grant            res;
        logic [ADDR_W-1:0] need;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] offs;
        logic [ADDR_W-1:0] seg_no;
        logic [ADDR_W-1:0] rel;
        int                cls;
        int                slot;
        int                nxt;
        logic              done;
        res  = '0;
        done = 1'b0;
        if (kind == REQ_ALLOC) begin
            need = {16'd0, nbytes} + LINK_BYTES;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                blk = MIN_BLOCK << c;
                if (!done && blk >= need && !list_empty[c]) begin
                    done = 1'b1;
                    res.granted = 1'b1;
                    res.addr = heap_base + c * SEG_BYTES + HEADER_BYTES
                               + list_head[c] * blk + LINK_BYTES;
                    if (list_head[c] == list_tail[c]) begin
                        list_empty[c] = 1'b1;
                    end else begin
                        nxt = slot_link[class_start[c] + list_head[c]];
                        if (nxt < class_slots[c]) list_head[c] = nxt;
                        else list_empty[c] = 1'b1;
                    end
                end
            end
        end else if (addr != '0) begin
            offs   = addr - LINK_BYTES - heap_base;
            seg_no = offs / SEG_BYTES;
            rel    = offs % SEG_BYTES;
            if (seg_no < NUM_CLASSES && rel >= HEADER_BYTES) begin
                cls  = int'(seg_no);
                slot = int'((rel - HEADER_BYTES) / (MIN_BLOCK << cls));
                if (slot < class_slots[cls]) begin
                    // no check for double free, the slot just goes on the tail
                    if (list_empty[cls]) begin
                        list_head[cls]  = slot;
                        list_empty[cls] = 1'b0;
                    end else begin
                        slot_link[class_start[cls] + list_tail[cls]] = slot;
                    end
                    list_tail[cls] = slot;
                end
            end
        end
        pending_grants.push_back(res);
    endtask

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        result_no     = 0;
        reset_lists();
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            reset_lists();
            pending_grants.delete();
        end else begin
            // a result always belongs to an earlier request, so compare first
            if (i_res_valid && i_res_ready) begin
                if (pending_grants.size() == 0) begin
                    report_mismatch("unexpected result, addr", i_res_data, '0);
                end else begin
                    want = pending_grants.pop_front();
                    if (i_res_user !== want.granted)
                        report_mismatch("granted", {31'd0, i_res_user}, {31'd0, want.granted});
                    if (i_res_data !== want.addr)
                        report_mismatch("block_addr", i_res_data, want.addr);
                end
                result_no++;
            end
            if (i_cfg_valid && i_cfg_ready) heap_base = i_cfg_data;
            if (i_req_valid && i_req_ready)
                serve_request(i_req_user, i_req_data[BYTES_W-1:0],
                              i_req_data[BYTES_W +: ADDR_W]);
        end
        o_outstanding = pending_grants.size();
    end

endmodule

[tb/tb_top.sv]
// tb_top: drives requests and heap base writes into the allocator with random
// idling on both channels; checking is done by sba_checker
// depends on sba_pkg, sba_checker, segregated_block_allocator_top
`timescale 1ns / 1ps

module tb_top;
    import sba_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 406;
    localparam int NUM_PHASES      = 4;
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 80, 0, 23};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 80, 23};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [ADDR_W-1:0]      i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // req_bytes, free_addr
    logic                   s_axis_tuser;   // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // block_addr
    logic                   m_axis_tuser;   // granted

    int                errors;
    int                outstanding;
    int                send_idle_pct;
    int                recv_stall_pct = 0;
    int                idle_cycles;
    logic [ADDR_W-1:0] heap_base_now;
    logic [ADDR_W-1:0] last_freed;
    logic [ADDR_W-1:0] live_blocks[$];

    segregated_block_allocator_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sba_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_user    (m_axis_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // granted blocks come back later as free requests
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready && m_axis_tuser)
            live_blocks.push_back(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] payload_addr(input int cls, input int slot);
        return heap_base_now + cls * SEG_BYTES + HEADER_BYTES + slot * (MIN_BLOCK << cls)
               + LINK_BYTES;
    endfunction

    // called at a falling edge, returns at the falling edge after the accept
    task automatic send_request(input logic kind, input logic [BYTES_W-1:0] nbytes,
                                input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {addr, nbytes};
        s_axis_tuser  = kind;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid = 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_heap_base(input logic [ADDR_W-1:0] new_base);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = new_base;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        // live blocks keep their slots, only the addresses move
        foreach (live_blocks[i]) live_blocks[i] = live_blocks[i] - heap_base_now + new_base;
        heap_base_now = new_base;
    endtask

    task automatic random_request();
        int                pick;
        int                cls;
        int                idx;
        logic [BYTES_W-1:0] nbytes;
        logic [ADDR_W-1:0]  addr;
        pick   = $urandom_range(99);
        nbytes = BYTES_W'($urandom);
        addr   = $urandom;
        if (pick < 50 || live_blocks.size() == 0 && pick < 80) begin
            cls = $urandom_range(9);
            if (cls == 0)
                nbytes = BYTES_W'($urandom_range(MIN_BLOCK - LINK_BYTES));
            else if (cls < NUM_CLASSES)
                nbytes = BYTES_W'($urandom_range((MIN_BLOCK << cls) - LINK_BYTES,
                                                 (MIN_BLOCK << (cls - 1)) - LINK_BYTES + 1));
            else if (cls == NUM_CLASSES)
                nbytes = BYTES_W'($urandom_range(16'hFFFF,
                                  (MIN_BLOCK << (NUM_CLASSES - 1)) - LINK_BYTES + 1));
            send_request(REQ_ALLOC, nbytes, addr);
        end else if (pick < 94 && live_blocks.size() != 0) begin
            idx  = $urandom_range(live_blocks.size() - 1);
            addr = live_blocks[idx];
            live_blocks.delete(idx);
            // now and then point into the middle of the payload
            if ($urandom_range(9) == 0) addr = addr + $urandom_range(MIN_BLOCK - LINK_BYTES - 1);
            last_freed = addr;
            send_request(REQ_FREE, nbytes, addr);
        end else begin
            case ($urandom_range(3))
                0: addr = '0;
                1: addr = $urandom;
                2: addr = last_freed;
                default: addr = heap_base_now + $urandom_range(NUM_CLASSES) * SEG_BYTES
                                + $urandom_range(HEADER_BYTES + LINK_BYTES - 1);
            endcase
            send_request(REQ_FREE, nbytes, addr);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] new_base;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ALLOC;
        send_idle_pct = 0;
        heap_base_now = '0;
        last_freed    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items at the reset heap base
        send_request(REQ_ALLOC, 16'd0, '0);
        send_request(REQ_ALLOC, BYTES_W'(MIN_BLOCK - LINK_BYTES), 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, BYTES_W'(MIN_BLOCK - LINK_BYTES + 1), '0);
        send_request(REQ_ALLOC, BYTES_W'((MIN_BLOCK << 7) - LINK_BYTES), '0);
        // top class now empty, then requests too large for any class
        send_request(REQ_ALLOC, BYTES_W'((MIN_BLOCK << 7) - LINK_BYTES), '0);
        send_request(REQ_ALLOC, BYTES_W'((MIN_BLOCK << 7) - LINK_BYTES + 1), '0);
        send_request(REQ_ALLOC, 16'hFFFF, '0);
        send_request(REQ_FREE, 16'hFFFF, '0);
        send_request(REQ_FREE, '0, payload_addr(7, 0));
        send_request(REQ_ALLOC, 16'd1000, '0);
        // double free of the same block
        send_request(REQ_FREE, '0, payload_addr(7, 0));
        send_request(REQ_ALLOC, 16'd2000, '0);
        send_request(REQ_ALLOC, 16'd2000, '0);
        send_request(REQ_FREE, '0, payload_addr(0, 1) + 5);
        send_request(REQ_FREE, '0, payload_addr(1, 0) - HEADER_BYTES + 3);
        send_request(REQ_FREE, '0, 32'hFFFF_FFFF);
        send_request(REQ_FREE, '0, payload_addr(7, 1));
        send_request(REQ_FREE, '0, 32'd3);
        send_request(REQ_FREE, '0, 32'd4);
        send_request(REQ_ALLOC, 16'd0, '0);
        send_request(REQ_ALLOC, 16'd0, '0);
        send_request(REQ_FREE, '0, payload_addr(6, 0));
        send_request(REQ_FREE, '0, payload_addr(0, 254));
        send_request(REQ_FREE, '0, payload_addr(0, 255));
        send_request(REQ_ALLOC, 16'd60, '0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: new_base = 32'hFFFF_FFFF;
                1: new_base = '0;
                2: new_base = $urandom;
                default: new_base = 32'hFFFF_F000;
            endcase
            write_heap_base(new_base);
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) wait_results_done();
                random_request();
            end
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
